// ===== rtl/oaht_pkg.sv =====
// Shared types and constants for the open-addressing hash table.
`timescale 1ns / 1ps

package oaht_pkg;

  localparam int KEY_W        = 32;
  localparam int VALUE_W      = 50;
  localparam int STATUS_W     = 2;
  localparam int SLOT_INDEX_W = 4;
  localparam int DEFAULT_TABLE_SIZE = 16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic MODE_LINEAR    = 1'b0;
  localparam logic MODE_QUADRATIC = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HOME,
    S_READ,
    S_CHECK
  } state_t;

  typedef struct packed {
    logic               used;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

endpackage

// ===== rtl/open_addressing_hash_table.sv =====
// Open-addressing hash table top level with a single slot memory and probe sequencer.
`timescale 1ns / 1ps

// Each transfer on the input is an insert or a search of a 32-bit key in a table of
// TABLE_SIZE slots, the home slot being the key modulo TABLE_SIZE and the probe order
// linear or quadratic as set by the configuration register. An item is taken in, then the
// key is multiplied by the reciprocal of TABLE_SIZE, then the remainder is corrected and
// the slot memory addressed, then each probe checks one slot, up to TABLE_SIZE probes; a
// finished item is held while the previous result still waits for its transfer. One read
// of the slot memory per cycle sets the probe rate. After reset the memory is cleared one
// slot per cycle before the first item is taken; the configuration register may be
// written during that pass.
module open_addressing_hash_table #(
  parameter int TABLE_SIZE = oaht_pkg::DEFAULT_TABLE_SIZE
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             probe_mode,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             operation,
  input  logic [oaht_pkg::KEY_W-1:0]       key,
  input  logic [oaht_pkg::VALUE_W-1:0]     value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [oaht_pkg::STATUS_W-1:0]    status,
  output logic [oaht_pkg::SLOT_INDEX_W-1:0] slot_index,
  output logic [oaht_pkg::VALUE_W-1:0]     found_value
);

  localparam int IW  = $clog2(TABLE_SIZE);
  localparam int IW1 = IW + 1;
  localparam logic [IW:0]   SIZE = IW1'(TABLE_SIZE);
  localparam logic [IW-1:0] LAST = IW'(TABLE_SIZE - 1);
  localparam logic [oaht_pkg::KEY_W-1:0] RECIP =
    oaht_pkg::KEY_W'((64'd1 << oaht_pkg::KEY_W) / TABLE_SIZE);

  oaht_pkg::state_t state, state_next;
  oaht_pkg::entry_t mem [TABLE_SIZE];
  oaht_pkg::entry_t rdata;
  oaht_pkg::entry_t wdata;

  logic                           mode;
  logic                           op;
  logic [oaht_pkg::KEY_W-1:0]     key_reg;
  logic [oaht_pkg::VALUE_W-1:0]   value_reg;
  logic [IW:0]                    quot;
  logic [IW-1:0]                  slot;
  logic [IW-1:0]                  probe;
  logic [IW-1:0]                  step;

  logic [2*oaht_pkg::KEY_W-1:0] recip_prod;
  logic [2*IW+1:0]              quot_mul;
  logic [IW:0]                  home_est;
  logic [IW-1:0]                home_slot;
  logic [IW-1:0] probe_step;
  logic [IW:0]   slot_sum;
  logic [IW-1:0] slot_next;
  logic [IW:0]   step_sum;
  logic [IW-1:0] step_next;

  logic          accept;
  logic          out_free;
  logic          finish;
  logic          match;
  logic          advance;
  logic          load_out;
  logic          mem_we;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] rd_addr;
  oaht_pkg::status_t        res_status;
  logic [IW+3:0]            res_slot_ext;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == oaht_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // The quotient estimate is the true quotient or one less, so one correction step is enough.
  assign recip_prod = key_reg * RECIP;
  assign quot_mul   = quot * SIZE;
  assign home_est   = key_reg[IW:0] - quot_mul[IW:0];
  assign home_slot  = (home_est >= SIZE) ? IW'(home_est - SIZE) : home_est[IW-1:0];

  // Quadratic probing adds 2i+1 at probe i, linear probing adds one.
  assign probe_step = (mode == oaht_pkg::MODE_QUADRATIC) ? step : IW'(1);
  assign slot_sum   = {1'b0, slot} + {1'b0, probe_step};
  assign slot_next  = (slot_sum >= SIZE) ? IW'(slot_sum - SIZE) : slot_sum[IW-1:0];
  assign step_sum   = {1'b0, step} + IW1'(2);
  assign step_next  = (step_sum >= SIZE) ? IW'(step_sum - SIZE) : step_sum[IW-1:0];

  assign match  = rdata.used && (rdata.key == key_reg);
  assign finish = !rdata.used || (op == oaht_pkg::OP_SEARCH && match) || (probe == LAST);

  always_comb begin
    if (op == oaht_pkg::OP_INSERT) begin
      res_status = rdata.used ? oaht_pkg::ST_FULL : oaht_pkg::ST_INSERTED;
    end else begin
      res_status = match ? oaht_pkg::ST_FOUND : oaht_pkg::ST_NOT_FOUND;
    end
  end

  assign res_slot_ext = (res_status == oaht_pkg::ST_INSERTED ||
                         res_status == oaht_pkg::ST_FOUND) ? {4'b0, slot} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oaht_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    advance    = 1'b0;
    load_out   = 1'b0;
    mem_we     = 1'b0;
    wr_addr    = slot;
    rd_addr    = slot;
    wdata      = '{used: 1'b1, key: key_reg, value: value_reg};
    case (state)
      oaht_pkg::S_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = probe;
        wdata   = '0;
        if (probe == LAST) begin
          state_next = oaht_pkg::S_IDLE;
        end
      end
      oaht_pkg::S_IDLE: begin
        if (accept) begin
          state_next = oaht_pkg::S_HOME;
        end
      end
      oaht_pkg::S_HOME: begin
        state_next = oaht_pkg::S_READ;
      end
      oaht_pkg::S_READ: begin
        rd_addr    = home_slot;
        state_next = oaht_pkg::S_CHECK;
      end
      oaht_pkg::S_CHECK: begin
        if (!finish) begin
          advance = 1'b1;
          rd_addr = slot_next;
        end else if (out_free) begin
          load_out   = 1'b1;
          mem_we     = (res_status == oaht_pkg::ST_INSERTED);
          state_next = oaht_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = oaht_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= oaht_pkg::MODE_LINEAR;
    end else if (cfg_valid && cfg_ready) begin
      mode <= probe_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe <= '0;
    end else if (state == oaht_pkg::S_CLEAR) begin
      probe <= (probe == LAST) ? '0 : probe + IW'(1);
    end else if (state == oaht_pkg::S_HOME) begin
      probe <= '0;
    end else if (advance) begin
      probe <= probe + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= operation;
      key_reg   <= key;
      value_reg <= value;
    end else if (state == oaht_pkg::S_HOME) begin
      quot <= recip_prod[oaht_pkg::KEY_W +: IW1];
    end else if (state == oaht_pkg::S_READ) begin
      slot <= home_slot;
      step <= IW'(1);
    end else if (advance) begin
      slot <= slot_next;
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status      <= res_status;
      slot_index  <= res_slot_ext[3:0];
      found_value <= (res_status == oaht_pkg::ST_FOUND) ? rdata.value : '0;
    end
  end

`ifndef ASSERT_OFF
  a_write_only_free_slot: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state != oaht_pkg::S_CLEAR) |-> (op == oaht_pkg::OP_INSERT && !rdata.used))
    else $error("slot memory written outside an insert into a free slot");

  a_accept_starts_home: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == oaht_pkg::S_HOME))
    else $error("accepted item did not start the home slot calculation");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (out_valid && state == oaht_pkg::S_IDLE))
    else $error("finished item did not produce a result");

  a_no_load_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !load_out)
    else $error("result overwritten while waiting for transfer");
`endif

endmodule
